@@ src/hcss_pkg.sv @@
// Shared types, character codes and the first-pass helper for the
// header comment and whitespace stripper. No dependencies.
`default_nettype none

package hcss_pkg;

	localparam int LOOKAHEAD_DEF = 14;
	localparam int KW_LEN = 14;
	localparam int SKIP_W = 4;

	localparam logic [SKIP_W-1:0] SKIP_LEN = SKIP_W'(KW_LEN - 1);

	localparam logic [7:0] SPACE = 8'h20;
	localparam logic [7:0] SLASH = 8'h2f;
	localparam logic [7:0] STAR = 8'h2a;
	localparam logic [7:0] CTRL_LIMIT = 8'd32;
	localparam logic [7:0] HIGH_LIMIT = 8'd128;

	localparam logic [7:0] KEYWORD [KW_LEN] = '{
		8'h44, 8'h4e, 8'h41, 8'h5f, 8'h44, 8'h45, 8'h50,
		8'h52, 8'h45, 8'h43, 8'h41, 8'h54, 8'h45, 8'h44
	};

	typedef struct packed {
		logic blk;
		logic [SKIP_W-1:0] skip;
		logic [7:0] prev;
	} pass_st_t;

	typedef struct packed {
		logic [7:0] data;
		logic has;
		logic eob;
	} res_t;

	typedef struct packed {
		logic lc;
		logic [7:0] ch;
	} settle_t;

	// first pass on a pending byte given its successor
	function automatic settle_t settle(input logic [7:0] r, input logic [7:0] nxt,
		input logic lc);
		settle_t s;
		s.lc = lc;
		if (r == SLASH && nxt == SLASH) begin
			s.lc = 1'b1;
		end else if (r < CTRL_LIMIT) begin
			s.lc = 1'b0;
		end
		s.ch = (s.lc || r < CTRL_LIMIT || r >= HIGH_LIMIT) ? SPACE : r;
		return s;
	endfunction

endpackage

`default_nettype wire

@@ src/hcss_pass.sv @@
// Second-pass decision on the window head: block comments, space folding,
// keyword skip. Combinational. Depends on hcss_pkg.
`default_nettype none

module hcss_pass #(
	parameter int WDEPTH = hcss_pkg::LOOKAHEAD_DEF + 1,
	parameter int FW = $clog2(hcss_pkg::LOOKAHEAD_DEF + 2)
) (
	input  logic [WDEPTH-1:0][7:0] src,
	input  logic [FW-1:0]          n,
	input  hcss_pkg::pass_st_t     st,
	output hcss_pkg::pass_st_t     st_nx,
	output logic                   keep,
	output logic [7:0]             kept,
	output logic [7:0]             head_nx
);

	logic [7:0] c0, c1, m0, m1;
	logic blk, drop, kw_hit;

	generate
		if (WDEPTH >= hcss_pkg::KW_LEN) begin : g_kw
			always_comb begin
				kw_hit = (n >= FW'(hcss_pkg::KW_LEN));
				for (int j = 0; j < hcss_pkg::KW_LEN; j++) begin
					if (src[j] != hcss_pkg::KEYWORD[j]) begin
						kw_hit = 1'b0;
					end
				end
			end
		end else begin : g_nokw
			assign kw_hit = 1'b0;
		end
	endgenerate

	always_comb begin
		c0 = (n != '0) ? src[0] : hcss_pkg::SPACE;
		c1 = (n > FW'(1)) ? src[1] : hcss_pkg::SPACE;
		m0 = c0;
		m1 = c1;
		blk = st.blk;
		drop = 1'b1;
		st_nx = st;
		keep = 1'b0;
		kept = c0;
		head_nx = c1;
		if (st.skip != '0) begin
			st_nx.skip = st.skip - 1'b1;
			st_nx.prev = c0;
		end else begin
			if (c0 == hcss_pkg::SLASH && c1 == hcss_pkg::STAR) begin
				blk = 1'b1;
				m0 = hcss_pkg::SPACE;
				m1 = hcss_pkg::SPACE;
			end
			if (m0 == hcss_pkg::STAR && m1 == hcss_pkg::SLASH) begin
				blk = 1'b0;
				m0 = hcss_pkg::SPACE;
				m1 = hcss_pkg::SPACE;
			end
			head_nx = m1;
			st_nx.blk = blk;
			st_nx.prev = m0;
			drop = blk || (m0 == hcss_pkg::SPACE && m1 == hcss_pkg::SPACE) ||
				(st.prev == hcss_pkg::STAR && m0 == hcss_pkg::SPACE);
			if (!drop) begin
				if (kw_hit) begin
					st_nx.skip = hcss_pkg::SKIP_LEN;
				end else begin
					keep = 1'b1;
					kept = m0;
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ src/hcss_core.sv @@
// Window registers, first pass on the pending byte, end-of-block drain.
// Depends on hcss_pkg and hcss_pass.
`default_nettype none

module hcss_core #(
	parameter int LOOKAHEAD = hcss_pkg::LOOKAHEAD_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         in_byte,
	input  logic               in_last,
	input  logic               res_room,
	output logic               res_valid,
	output hcss_pkg::res_t     res
);

	localparam int WDEPTH = LOOKAHEAD + 1;
	localparam int FW = $clog2(LOOKAHEAD + 2);

	logic [WDEPTH-1:0][7:0] win_q, win_d, a, src, shifted;
	logic [FW-1:0] fill_q, n;
	logic lc_q, flush_q, lc1, has_pend, full, accept, step, done;
	logic keep;
	logic [7:0] r_pend, b_app, kept, head_nx;
	hcss_pkg::settle_t s1, s2;
	hcss_pkg::pass_st_t pst_q, pst_nx;

	always_comb begin
		r_pend = hcss_pkg::SPACE;
		for (int i = 0; i < WDEPTH; i++) begin
			if (FW'(i + 1) == fill_q) begin
				r_pend = win_q[i];
			end
		end
		has_pend = (fill_q != '0);
		s1 = hcss_pkg::settle(r_pend, in_byte, lc_q);
		lc1 = has_pend ? s1.lc : lc_q;
		s2 = hcss_pkg::settle(in_byte, hcss_pkg::SPACE, lc1);
		b_app = in_last ? s2.ch : in_byte;
		a = win_q;
		for (int i = 0; i < WDEPTH; i++) begin
			if (has_pend && FW'(i + 1) == fill_q) begin
				a[i] = s1.ch;
			end
			if (FW'(i) == fill_q) begin
				a[i] = b_app;
			end
		end
	end

	assign full = (fill_q == FW'(LOOKAHEAD));
	assign src = flush_q ? win_q : a;
	assign n = flush_q ? fill_q : FW'(LOOKAHEAD);

	hcss_pass #(
		.WDEPTH(WDEPTH),
		.FW(FW)
	) u_pass (
		.src(src),
		.n(n),
		.st(pst_q),
		.st_nx(pst_nx),
		.keep(keep),
		.kept(kept),
		.head_nx(head_nx)
	);

	always_comb begin
		for (int i = 0; i < WDEPTH - 1; i++) begin
			shifted[i] = src[i + 1];
		end
		shifted[WDEPTH-1] = src[WDEPTH-1];
		shifted[0] = head_nx;
	end

	assign in_ready = !flush_q && res_room;
	assign accept = in_valid && in_ready;
	assign step = flush_q && res_room;
	assign done = step && (fill_q == '0);

	assign res_valid = (accept && !in_last && full && keep) || (step && !done && keep) || done;
	assign res.data = done ? 8'h00 : kept;
	assign res.has = !done;
	assign res.eob = done;

	always_comb begin
		win_d = win_q;
		if (accept) begin
			win_d = (!in_last && full) ? shifted : a;
		end else if (step && !done) begin
			win_d = shifted;
		end
	end

	always_ff @(posedge clk) begin
		win_q <= win_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			lc_q <= 1'b0;
			flush_q <= 1'b0;
			pst_q <= '{blk: 1'b0, skip: '0, prev: hcss_pkg::SPACE};
		end else if (accept) begin
			lc_q <= lc1;
			if (in_last) begin
				flush_q <= 1'b1;
				fill_q <= fill_q + 1'b1;
			end else if (full) begin
				pst_q <= pst_nx;
			end else begin
				fill_q <= fill_q + 1'b1;
			end
		end else if (step) begin
			if (done) begin
				fill_q <= '0;
				lc_q <= 1'b0;
				flush_q <= 1'b0;
				pst_q <= '{blk: 1'b0, skip: '0, prev: hcss_pkg::SPACE};
			end else begin
				pst_q <= pst_nx;
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ src/hcss_obuf.sv @@
// Two-entry result buffer between the core and the output stream.
// Depends on hcss_pkg.
`default_nettype none

module hcss_obuf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  hcss_pkg::res_t din,
	output logic           room,
	output logic           out_valid,
	input  logic           out_ready,
	output hcss_pkg::res_t dout
);

	logic [1:0] cnt_q;
	hcss_pkg::res_t head_q, tail_q;
	logic pop;

	assign out_valid = (cnt_q != 2'd0);
	assign room = (cnt_q != 2'd2);
	assign pop = out_valid && out_ready;
	assign dout = head_q;

	always_ff @(posedge clk) begin
		if (push && pop) begin
			if (cnt_q == 2'd1) begin
				head_q <= din;
			end else begin
				head_q <= tail_q;
				tail_q <= din;
			end
		end else if (pop) begin
			head_q <= tail_q;
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				head_q <= din;
			end else begin
				tail_q <= din;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

`default_nettype wire

@@ src/header_comment_space_stripper_top.sv @@
// Results are registered in hcss_obuf and leave on m_axis in the order they arise.
// Throughput: one byte per cycle while hcss_obuf has room and no drain is running;
// the first LOOKAHEAD bytes of a block give no result. A byte with tlast starts a
// drain of up to LOOKAHEAD+1 held bytes, then the end marker, via the second-pass
// logic; s_axis_tready is low meanwhile. Reset: arst_n asynchronous, clears control
// state; window contents are not cleared. Depends on hcss_pkg, hcss_core, hcss_obuf.
`default_nettype none

module header_comment_space_stripper_top #(
	parameter int LOOKAHEAD = hcss_pkg::LOOKAHEAD_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] in_byte
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] out_byte
	output logic       m_axis_tuser,  // [0] has_byte
	output logic       m_axis_tlast
);

	logic res_room, res_valid;
	hcss_pkg::res_t res, dout;

	hcss_core #(
		.LOOKAHEAD(LOOKAHEAD)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_byte(s_axis_tdata),
		.in_last(s_axis_tlast),
		.res_room(res_room),
		.res_valid(res_valid),
		.res(res)
	);

	hcss_obuf u_obuf (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_valid),
		.din(res),
		.room(res_room),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.dout(dout)
	);

	assign m_axis_tdata = dout.data;
	assign m_axis_tuser = dout.has;
	assign m_axis_tlast = dout.eob;

endmodule

`default_nettype wire

@@ tb/sv/header_comment_space_stripper_top_tb.sv @@
// Testbench for header_comment_space_stripper_top: directed and random text blocks in, cleaned bytes
// checked against an in-bench model of the comment and whitespace stripper.
// Depends on hcss_pkg and the RTL of the top level.
`timescale 1ns / 1ps

module header_comment_space_stripper_top_tb;

	localparam int LA = hcss_pkg::LOOKAHEAD_DEF;
	localparam int N_RANDOM = 480;
	localparam int IDLE_LIMIT = 1000;

	typedef struct {
		logic [7:0] ch;
		logic last;
		bit hold;
	} text_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b1;
	logic [7:0] m_axis_tdata;
	logic m_axis_tuser;
	logic m_axis_tlast;

	text_req_t text_reqs[$];
	logic [7:0] blk_buf[$];
	hcss_pkg::res_t clean_exp[$];

	// stripper model state
	logic [7:0] win [0:LA];
	int unsigned fill;
	bit line_cmt;
	bit blk_cmt;
	int unsigned skip_cnt;
	logic [7:0] prev_ch;

	int errors = 0;
	int n_bytes = 0;
	int n_blocks = 0;
	int n_results = 0;
	int n_kept = 0;
	int idle_cnt = 0;
	bit req_taken = 1'b0;

	header_comment_space_stripper_top #(
		.LOOKAHEAD(LA)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void strip_clear();
		fill = 0;
		line_cmt = 1'b0;
		blk_cmt = 1'b0;
		skip_cnt = 0;
		prev_ch = hcss_pkg::SPACE;
	endfunction

	function automatic logic [7:0] win_at(int unsigned pos, int unsigned n);
		if (pos < n && pos < LA + 1) begin
			return win[pos];
		end
		return hcss_pkg::SPACE;
	endfunction

	// line comments, control and high bytes on the newest byte, once its successor is known
	function automatic void first_pass_tail(logic [7:0] nxt);
		int unsigned idx;
		logic [7:0] r;
		if (fill == 0 || fill > LA + 1) begin
			return;
		end
		idx = fill - 1;
		r = win[idx];
		if (r == hcss_pkg::SLASH && nxt == hcss_pkg::SLASH) begin
			line_cmt = 1'b1;
		end else if (r < hcss_pkg::CTRL_LIMIT) begin
			line_cmt = 1'b0;
		end
		if (line_cmt || r < hcss_pkg::CTRL_LIMIT || r >= hcss_pkg::HIGH_LIMIT) begin
			win[idx] = hcss_pkg::SPACE;
		end
	endfunction

	function automatic bit keyword_at_head(int unsigned n);
		int j;
		for (j = 0; j < hcss_pkg::KW_LEN; j++) begin
			if (win_at(j, n) != hcss_pkg::KEYWORD[j]) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	function automatic bit second_pass_head(int unsigned n, output logic [7:0] kept);
		logic [7:0] c0;
		logic [7:0] c1;
		bit keep;
		c0 = win_at(0, n);
		c1 = win_at(1, n);
		keep = 1'b0;
		kept = 8'h00;
		if (skip_cnt > 0) begin
			skip_cnt--;
			prev_ch = c0;
			return 1'b0;
		end
		if (c0 == hcss_pkg::SLASH && c1 == hcss_pkg::STAR) begin
			blk_cmt = 1'b1;
			c0 = hcss_pkg::SPACE;
			c1 = hcss_pkg::SPACE;
		end
		if (c0 == hcss_pkg::STAR && c1 == hcss_pkg::SLASH) begin
			blk_cmt = 1'b0;
			c0 = hcss_pkg::SPACE;
			c1 = hcss_pkg::SPACE;
		end
		if (n > 0) begin
			win[0] = c0;
		end
		if (n > 1) begin
			win[1] = c1;
		end
		if (blk_cmt) begin
		end else if (c0 == hcss_pkg::SPACE && c1 == hcss_pkg::SPACE) begin
		end else if (prev_ch == hcss_pkg::STAR && c0 == hcss_pkg::SPACE) begin
		end else if (keyword_at_head(n)) begin
			skip_cnt = hcss_pkg::KW_LEN - 1;
		end else begin
			keep = 1'b1;
			kept = c0;
		end
		prev_ch = c0;
		return keep;
	endfunction

	function automatic void drop_head();
		int unsigned i;
		if (fill == 0 || fill > LA + 1) begin
			return;
		end
		for (i = 0; i + 1 < fill; i++) begin
			win[i] = win[i + 1];
		end
		fill--;
	endfunction

	function automatic void push_clean(logic [7:0] b, logic has, logic eob);
		hcss_pkg::res_t r;
		r.data = b;
		r.has = has;
		r.eob = eob;
		clean_exp.push_back(r);
	endfunction

	function automatic void strip_predict(logic [7:0] b, logic last);
		logic [7:0] kept;
		if (fill > LA) begin
			fill = LA;
		end
		first_pass_tail(b);
		win[fill] = b;
		fill++;
		if (!last) begin
			if (fill == LA + 1) begin
				if (second_pass_head(LA, kept)) begin
					push_clean(kept, 1'b1, 1'b0);
				end
				drop_head();
			end
		end else begin
			first_pass_tail(hcss_pkg::SPACE);
			while (fill > 0) begin
				if (second_pass_head(fill, kept)) begin
					push_clean(kept, 1'b1, 1'b0);
				end
				drop_head();
			end
			push_clean(8'h00, 1'b0, 1'b1);
			strip_clear();
		end
	endfunction

	function automatic logic [7:0] text_char();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			return 8'h61 + 8'($urandom_range(0, 25));
		end else if (pick < 55) begin
			return hcss_pkg::SPACE;
		end else if (pick < 65) begin
			return hcss_pkg::SLASH;
		end else if (pick < 75) begin
			return hcss_pkg::STAR;
		end else if (pick < 80) begin
			return 8'h0a;
		end else if (pick < 85) begin
			return 8'($urandom_range(0, 31));
		end else if (pick < 90) begin
			return 8'($urandom_range(128, 255));
		end
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic add_text(string s);
		int i;
		for (i = 0; i < s.len(); i++) begin
			blk_buf.push_back(s[i]);
		end
	endtask

	// first n bytes of the skipped keyword
	task automatic add_keyword(int n);
		int j;
		for (j = 0; j < n; j++) begin
			blk_buf.push_back(hcss_pkg::KEYWORD[j]);
		end
	endtask

	task automatic close_block(bit pause);
		text_req_t it;
		int i;
		for (i = 0; i < blk_buf.size(); i++) begin
			it.ch = blk_buf[i];
			it.last = (i == blk_buf.size() - 1);
			it.hold = pause && (i == 0);
			text_reqs.push_back(it);
		end
		blk_buf.delete();
	endtask

	initial begin
		int n_dir;
		int len;
		int pick;
		int kw_n;
		int blk_no;
		bit noise;
		strip_clear();

		// keyword filling a whole block, comments of both kinds, control and high bytes
		add_keyword(hcss_pkg::KW_LEN);
		close_block(1'b0);
		add_text("/*x*/a  b//c");
		blk_buf.push_back(8'h01);
		blk_buf.push_back(8'hff);
		add_text("* y");
		close_block(1'b0);
		add_text("*");
		close_block(1'b0);
		n_dir = text_reqs.size();

		blk_no = 0;
		while (text_reqs.size() < n_dir + N_RANDOM) begin
			noise = ($urandom_range(0, 9) == 0);
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(31, 70) : $urandom_range(1, 30);
			while (blk_buf.size() < len) begin
				pick = $urandom_range(0, 99);
				if (noise) begin
					blk_buf.push_back(8'($urandom_range(0, 255)));
				end else if (pick < 8) begin
					kw_n = $urandom_range(0, 1) ? hcss_pkg::KW_LEN :
						$urandom_range(1, hcss_pkg::KW_LEN - 1);
					add_keyword(kw_n);
				end else if (pick < 12) begin
					add_text("/*");
				end else if (pick < 16) begin
					add_text("*/");
				end else if (pick < 19) begin
					add_text("//");
				end else begin
					blk_buf.push_back(text_char());
				end
			end
			close_block(blk_no % 8 == 3);
			blk_no++;
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (text_reqs.size() != 0 || s_axis_tvalid || clean_exp.size() != 0) begin
			@(posedge clk);
		end
		repeat (LA + 8) @(posedge clk);

		$display("Sent %0d bytes in %0d text blocks (%0d directed bytes).",
			n_bytes, n_blocks, n_dir);
		$display("Checked %0d results, %0d of them kept bytes.", n_results, n_kept);
		if (errors == 0) begin
			$display("header_comment_space_stripper_top_tb OK");
		end else begin
			$display("header_comment_space_stripper_top_tb NOT OK");
		end
		$finish;
	end

	// request driver: bursts with random gaps, optional drain hold before a block
	int burst_left = 0;
	int gap_left = 0;

	always @(negedge clk) begin : drv
		text_req_t it;
		if (arst_n && (!s_axis_tvalid || req_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (text_reqs.size() == 0) begin
				s_axis_tvalid <= 1'b0;
			end else if (text_reqs[0].hold && clean_exp.size() != 0) begin
				s_axis_tvalid <= 1'b0;
			end else begin
				it = text_reqs.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= it.ch;
				s_axis_tlast <= it.last;
				if (burst_left == 0) begin
					burst_left = $urandom_range(0, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left--;
				end
			end
		end
	end

	// result side backpressure; the mode (always ready, fixed pattern or random) is redrawn periodically
	int stall_cyc = 0;
	int stall_mode = 0;
	logic [15:0] stall_pat = 16'hffff;

	always @(negedge clk) begin
		if (stall_cyc % 64 == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_pat = 16'($urandom_range(0, 65535)) | 16'h0001;
		end
		case (stall_mode)
			0: begin
				m_axis_tready <= 1'b1;
			end
			1: begin
				m_axis_tready <= stall_pat[stall_cyc % 16];
			end
			default: begin
				m_axis_tready <= ($urandom_range(0, 3) != 0);
			end
		endcase
		stall_cyc++;
	end

	always @(posedge clk) begin : mon
		hcss_pkg::res_t exp_r;
		bit moved;
		req_taken = 1'b0;
		moved = 1'b0;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				moved = 1'b1;
				n_results++;
				if (m_axis_tuser === 1'b1) begin
					n_kept++;
				end
				if (clean_exp.size() == 0) begin
					$error("unexpected result: out_byte %0h has_byte %0b end_of_block %0b",
						m_axis_tdata, m_axis_tuser, m_axis_tlast);
					errors++;
				end else begin
					exp_r = clean_exp.pop_front();
					if (m_axis_tdata !== exp_r.data) begin
						$error("out_byte: expected %0h, got %0h", exp_r.data, m_axis_tdata);
						errors++;
					end
					if (m_axis_tuser !== exp_r.has) begin
						$error("has_byte: expected %0b, got %0b", exp_r.has, m_axis_tuser);
						errors++;
					end
					if (m_axis_tlast !== exp_r.eob) begin
						$error("end_of_block: expected %0b, got %0b", exp_r.eob, m_axis_tlast);
						errors++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				moved = 1'b1;
				req_taken = 1'b1;
				n_bytes++;
				if (s_axis_tlast) begin
					n_blocks++;
				end
				strip_predict(s_axis_tdata, s_axis_tlast);
			end
			idle_cnt = moved ? 0 : idle_cnt + 1;
			if (idle_cnt >= IDLE_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
				$display("header_comment_space_stripper_top_tb NOT OK");
				$finish;
			end
		end
	end

endmodule

@@ filelist.f @@
src/hcss_pkg.sv
src/hcss_pass.sv
src/hcss_core.sv
src/hcss_obuf.sv
src/header_comment_space_stripper_top.sv
tb/sv/header_comment_space_stripper_top_tb.sv
